// File: rtl/core/lvcd_pkg.sv
// shared constants and types for the logic value change detector
`timescale 1ns / 1ps
package lvcd_pkg;

	localparam int CHANNELS_DEF = 64;
	localparam int SAMPLE_W     = 64;
	localparam int TIME_W       = 64;
	localparam int CH_W         = 6;
	localparam int CNT_W        = 7;
	localparam int RATE_W       = 32;
	localparam int STEP_W       = 30;
	localparam int DIV_STEPS    = STEP_W;
	localparam int DIV_CNT_W    = 5;
	localparam int LANE_W       = 8;
	localparam int TDATA_W      = 72;
	localparam int CFG_IDX_W    = 1;

	localparam logic [STEP_W-1:0] PERIOD_GHZ = 30'd1000000000;
	localparam logic [STEP_W-1:0] PERIOD_MHZ = 30'd1000000;
	localparam logic [STEP_W-1:0] PERIOD_KHZ = 30'd1000;

	// step for the reset rate of 1 Hz
	localparam logic [STEP_W-1:0] STEP_WHOLE_RST = PERIOD_KHZ;
	localparam logic [RATE_W-1:0] STEP_REM_RST   = '0;
	localparam logic [RATE_W-1:0] RATE_RST       = 32'd1;
	localparam logic [CNT_W-1:0]  CH_USE_RST     = 7'd64;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS    = 1'b1;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_END    = 1'b1;

	typedef struct packed {
		logic [STEP_W-1:0] whole;
		logic [RATE_W-1:0] rem;
	} step_t;

	typedef struct packed {
		logic            hit;
		logic [CH_W-1:0] chan;
		logic            level;
	} pick_t;

endpackage

// File: rtl/core/lvcd_lane.sv
// one lane: lowest changed channel within an eight channel slice
`timescale 1ns / 1ps
module lvcd_lane (
	input  logic [lvcd_pkg::LANE_W-1:0] mask,
	input  logic [lvcd_pkg::LANE_W-1:0] bits,
	output lvcd_pkg::pick_t             res
);

	always_comb begin
		res = '0;
		for (int i = lvcd_pkg::LANE_W - 1; i >= 0; i--) begin
			if (mask[i]) begin
				res.hit   = 1'b1;
				res.chan  = lvcd_pkg::CH_W'(i);
				res.level = bits[i];
			end
		end
	end

endmodule

// File: rtl/core/lvcd_pick.sv
// lanes side by side plus the merge that picks the lowest changed channel
`timescale 1ns / 1ps
module lvcd_pick #(
	parameter int CHANNELS = lvcd_pkg::CHANNELS_DEF
) (
	input  logic [CHANNELS-1:0] mask,
	input  logic [CHANNELS-1:0] bits,
	output lvcd_pkg::pick_t     res
);

	localparam int LANES = (CHANNELS + lvcd_pkg::LANE_W - 1) / lvcd_pkg::LANE_W;
	localparam int PAD_W = LANES * lvcd_pkg::LANE_W;

	logic [PAD_W-1:0] mask_pad;
	logic [PAD_W-1:0] bits_pad;
	lvcd_pkg::pick_t  lane_res [LANES];

	assign mask_pad = PAD_W'(mask);
	assign bits_pad = PAD_W'(bits);

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		lvcd_lane u_lane (
			.mask (mask_pad[l*lvcd_pkg::LANE_W +: lvcd_pkg::LANE_W]),
			.bits (bits_pad[l*lvcd_pkg::LANE_W +: lvcd_pkg::LANE_W]),
			.res  (lane_res[l])
		);
	end

	// lowest lane with a hit wins
	always_comb begin
		res = '0;
		for (int l = LANES - 1; l >= 0; l--) begin
			if (lane_res[l].hit) begin
				res.hit   = 1'b1;
				res.chan  = lane_res[l].chan + lvcd_pkg::CH_W'(l * lvcd_pkg::LANE_W);
				res.level = lane_res[l].level;
			end
		end
	end

endmodule

// File: rtl/core/lvcd_step_div.sv
// restoring divider that derives the time step from the sample rate
`timescale 1ns / 1ps
module lvcd_step_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lvcd_pkg::RATE_W-1:0]   rate,
	output logic                          busy,
	output lvcd_pkg::step_t               step
);

	logic [lvcd_pkg::STEP_W-1:0]    dvd_q;
	logic [lvcd_pkg::STEP_W-1:0]    quo_q;
	logic [lvcd_pkg::RATE_W-1:0]    rem_q;
	logic [lvcd_pkg::RATE_W-1:0]    div_q;
	logic [lvcd_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic [lvcd_pkg::STEP_W-1:0]    period;
	logic [lvcd_pkg::RATE_W:0]      shifted;
	logic                           ge;
	logic [lvcd_pkg::RATE_W:0]      diff;

	always_comb begin
		if (rate > lvcd_pkg::RATE_W'(lvcd_pkg::PERIOD_MHZ)) begin
			period = lvcd_pkg::PERIOD_GHZ;
		end else if (rate > lvcd_pkg::RATE_W'(lvcd_pkg::PERIOD_KHZ)) begin
			period = lvcd_pkg::PERIOD_MHZ;
		end else begin
			period = lvcd_pkg::PERIOD_KHZ;
		end
	end

	assign shifted = {rem_q, dvd_q[lvcd_pkg::STEP_W-1]};
	assign ge      = shifted >= {1'b0, div_q};
	assign diff    = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= lvcd_pkg::STEP_WHOLE_RST;
			rem_q  <= lvcd_pkg::STEP_REM_RST;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[lvcd_pkg::STEP_W-2:0], ge};
			rem_q <= ge ? diff[lvcd_pkg::RATE_W-1:0] : shifted[lvcd_pkg::RATE_W-1:0];
			if (cnt_q == lvcd_pkg::DIV_CNT_W'(lvcd_pkg::DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= period;
			div_q <= rate;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[lvcd_pkg::STEP_W-2:0], 1'b0};
		end
	end

	assign busy       = busy_q;
	assign step.whole = quo_q;
	assign step.rem   = rem_q;

endmodule

// File: rtl/core/logic_value_change_detector.sv
// top level: change detection, pending changes, time keeping and result register
// results pass the pending, then the result register; later ones one per cycle when not stalled
// throughput: one item per cycle while each causes at most one result and nothing stalls;
//   a sample with several changed channels holds the input until its last change is loaded
// a sample_rate write keeps both channels stalled while the step divider runs
// reset: previous sample and time clear, first sample reports all channels, rate 1, 64 channels
`timescale 1ns / 1ps
module logic_value_change_detector #(
	parameter int CHANNELS = lvcd_pkg::CHANNELS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [lvcd_pkg::SAMPLE_W-1:0]     s_tdata,   // sample_bits
	input  logic                              s_tuser,   // op
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [lvcd_pkg::TDATA_W-1:0]      m_tdata,   // event_time, channel, level, zero pad
	output logic                              m_tuser,   // is_end_marker
	output logic                              m_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lvcd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lvcd_pkg::RATE_W-1:0]       cfg_data
);

	logic [lvcd_pkg::RATE_W-1:0] rate_q;
	logic [lvcd_pkg::CNT_W-1:0]  ch_use_q;
	logic [CHANNELS-1:0]         prev_q;
	logic                        seen_q;
	logic [lvcd_pkg::TIME_W-1:0] time_whole_q;
	logic [lvcd_pkg::RATE_W-1:0] time_rem_q;

	logic [CHANNELS-1:0]         pend_mask_q;
	logic [CHANNELS-1:0]         pend_bits_q;
	logic [lvcd_pkg::TIME_W-1:0] pend_time_q;
	logic                        pend_end_q;

	logic                        m_valid_q;
	logic [lvcd_pkg::TIME_W-1:0] m_time_q;
	logic [lvcd_pkg::CH_W-1:0]   m_chan_q;
	logic                        m_level_q;
	logic                        m_end_q;
	logic                        m_last_q;

	logic                        div_busy;
	lvcd_pkg::step_t             step;
	lvcd_pkg::pick_t             pick;

	logic                        cfg_xfer;
	logic                        rate_wr;
	logic [lvcd_pkg::RATE_W-1:0] rate_new;
	logic                        in_xfer;
	logic [lvcd_pkg::CNT_W-1:0]  ch_n;
	logic [CHANNELS-1:0]         use_mask;
	logic [CHANNELS-1:0]         bits;
	logic [CHANNELS-1:0]         changed;
	logic [CHANNELS-1:0]         rest;
	logic                        pend_valid;
	logic                        load;
	logic                        load_last;
	logic                        pend_done;
	logic [lvcd_pkg::TIME_W-1:0] now;
	logic [lvcd_pkg::RATE_W:0]   rem_sum;
	logic                        rem_wrap;
	logic [lvcd_pkg::RATE_W:0]   rem_sub;

	lvcd_step_div u_step_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rate_wr),
		.rate   (rate_new),
		.busy   (div_busy),
		.step   (step)
	);

	lvcd_pick #(
		.CHANNELS (CHANNELS)
	) u_pick (
		.mask (pend_mask_q),
		.bits (pend_bits_q),
		.res  (pick)
	);

	// configuration
	assign cfg_ready = !div_busy;
	assign cfg_xfer  = cfg_valid && cfg_ready;
	assign rate_wr   = cfg_xfer && (cfg_index == lvcd_pkg::REG_SAMPLE_RATE);
	assign rate_new  = (cfg_data == '0) ? lvcd_pkg::RATE_RST : cfg_data;

	// channels in use, clamped to the built width
	assign ch_n = (ch_use_q > lvcd_pkg::CNT_W'(CHANNELS)) ? lvcd_pkg::CNT_W'(CHANNELS) : ch_use_q;

	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			use_mask[i] = lvcd_pkg::CNT_W'(i) < ch_n;
		end
	end

	assign bits    = s_tdata[CHANNELS-1:0];
	assign changed = seen_q ? ((bits ^ prev_q) & use_mask) : use_mask;

	// pending changes drain one per cycle into the result register unless the output stalls
	assign pend_valid = pend_end_q || (|pend_mask_q);
	assign rest       = pend_mask_q & (pend_mask_q - CHANNELS'(1));
	assign load       = pend_valid && (!m_valid_q || m_tready);
	assign load_last  = pend_end_q || (rest == '0);
	assign pend_done  = load && load_last;

	assign s_tready = !div_busy && (!pend_valid || pend_done);
	assign in_xfer  = s_tvalid && s_tready;

	// rounded time, half up
	assign now = time_whole_q + lvcd_pkg::TIME_W'({time_rem_q, 1'b0} >= {1'b0, rate_q});

	assign rem_sum  = {1'b0, time_rem_q} + {1'b0, step.rem};
	assign rem_wrap = rem_sum >= {1'b0, rate_q};
	assign rem_sub  = rem_sum - {1'b0, rate_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q       <= lvcd_pkg::RATE_RST;
			ch_use_q     <= lvcd_pkg::CH_USE_RST;
			prev_q       <= '0;
			seen_q       <= 1'b0;
			time_whole_q <= '0;
			time_rem_q   <= '0;
		end else begin
			if (cfg_xfer && (cfg_index == lvcd_pkg::REG_CHANNELS)) begin
				ch_use_q <= cfg_data[lvcd_pkg::CNT_W-1:0];
			end
			if (rate_wr) begin
				rate_q       <= rate_new;
				time_whole_q <= '0;
				time_rem_q   <= '0;
			end else if (in_xfer && (s_tuser == lvcd_pkg::OP_SAMPLE)) begin
				prev_q       <= bits;
				seen_q       <= 1'b1;
				time_whole_q <= time_whole_q + lvcd_pkg::TIME_W'(step.whole)
					+ lvcd_pkg::TIME_W'(rem_wrap);
				time_rem_q   <= rem_wrap ? rem_sub[lvcd_pkg::RATE_W-1:0]
					: rem_sum[lvcd_pkg::RATE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_mask_q <= '0;
			pend_end_q  <= 1'b0;
		end else if (in_xfer) begin
			pend_end_q  <= (s_tuser == lvcd_pkg::OP_END);
			pend_mask_q <= (s_tuser == lvcd_pkg::OP_END) ? '0 : changed;
		end else if (load) begin
			pend_end_q  <= 1'b0;
			pend_mask_q <= pend_end_q ? pend_mask_q : rest;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pend_bits_q <= bits;
			pend_time_q <= now;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_time_q  <= pend_time_q;
			m_chan_q  <= pend_end_q ? '0 : pick.chan;
			m_level_q <= pend_end_q ? 1'b0 : pick.level;
			m_end_q   <= pend_end_q;
			m_last_q  <= load_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = lvcd_pkg::TDATA_W'({m_level_q, m_chan_q, m_time_q});
	assign m_tuser  = m_end_q;
	assign m_tlast  = m_last_q;

endmodule
